>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the event-flag/timer block.
// Define NO_ASSERTIONS to compile them away; needs a clock named clk and reset rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(label, prop, msg)
`define ASSERT_CLK_ALWAYS(label, prop, msg)
`endif
`endif

>>> hw/rtl/tefpt_pkg.sv
// Shared types and constants for the task event-flag / periodic timer block.
// No dependencies.
package tefpt_pkg;

  localparam int CMD_W   = 3;
  localparam int TASK_W  = 4;
  localparam int DATA_W  = 32;
  localparam int PEND_W  = 16;

  localparam int TASKS_DEF     = 16;
  localparam int TIMER_BIT_DEF = 0;

  localparam logic [CMD_W-1:0] CMD_SEND    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_RECEIVE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_ARM     = 3'd2;
  localparam logic [CMD_W-1:0] CMD_CANCEL  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_TICK    = 3'd4;

  // One task's state, kept as one memory row.
  typedef struct packed {
    logic [DATA_W-1:0] reload;
    logic [DATA_W-1:0] count;
    logic [DATA_W-1:0] flags;
  } row_t;

  localparam int ROW_W = $bits(row_t);

endpackage

>>> hw/rtl/tefpt_upd.sv
// Shared row update unit: applies one command to one task's row.
// Depends on tefpt_pkg. Holds the single decrementer used by the tick sweep.
module tefpt_upd import tefpt_pkg::*; #(
  parameter int TIMER_BIT = TIMER_BIT_DEF
) (
  input  logic [CMD_W-1:0]  cmd,
  input  logic [DATA_W-1:0] value,
  input  row_t              row_in,
  output row_t              row_out,
  output logic [DATA_W-1:0] taken
);

  localparam logic [DATA_W-1:0] TB = DATA_W'(1) << TIMER_BIT;

  logic [DATA_W-1:0] dec;

  assign dec = row_in.count - DATA_W'(1);

  always_comb begin
    row_out = row_in;
    taken   = '0;
    case (cmd)
      CMD_SEND: begin
        row_out.flags = row_in.flags | value;
      end
      CMD_RECEIVE: begin
        taken         = row_in.flags & value;
        row_out.flags = row_in.flags & ~value;
      end
      CMD_ARM: begin
        row_out.count  = value;
        row_out.reload = value;
      end
      CMD_CANCEL: begin
        row_out.count = '0;
        row_out.flags = row_in.flags & ~TB;
      end
      CMD_TICK: begin
        if (row_in.count != '0) begin
          if (dec == '0) begin
            row_out.flags = row_in.flags | TB;
            row_out.count = row_in.reload;
          end else begin
            row_out.count = dec;
          end
        end
      end
      default: begin
        row_out = row_in;
      end
    endcase
  end

endmodule

>>> hw/rtl/tefpt_mem.sv
// Task state memory: one row per task, registered read, one write port.
// Depends on tefpt_pkg. Per-row valid bits make unwritten rows read as zero.
module tefpt_mem import tefpt_pkg::*; #(
  parameter int DEPTH = TASKS_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [AW-1:0] rd_addr,
  output row_t          rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  row_t          wr_data
);

  row_t             mem [DEPTH];
  logic [DEPTH-1:0] vld;
  row_t             q;
  logic             q_vld;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      q_vld <= 1'b0;
    end else begin
      if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
      q_vld <= vld[rd_addr];
    end
  end

  assign rd_data = q_vld ? q : '0;

endmodule

>>> hw/rtl/task_event_flags_periodic_timers_top.sv
// Per-task event flags with periodic timers, stream in / stream out.
// A send/receive/arm/cancel on a valid task reads its row (S_RD), updates and writes it (S_EX),
// then loads the result (S_DONE); a bad task or unused code goes straight to S_DONE; a tick
// sweeps all TASKS rows with one decrementer. One item at a time: s_axis_tready is high only
// in S_IDLE, entered as the result is loaded; S_DONE waits while m_axis_tready holds a result.
// Reset (rst, synchronous, active high) clears control and per-row valid bits; no clearing pass.
`include "assert_macros.svh"
module task_event_flags_periodic_timers_top import tefpt_pkg::*; #(
  parameter int TASKS     = TASKS_DEF,
  parameter int TIMER_BIT = TIMER_BIT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // [2:0] cmd, [6:3] task_req, [38:7] value, [39] zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata   // [31:0] matched_events, [47:32] pending_tasks
);

  localparam int TW = (TASKS > 1) ? $clog2(TASKS) : 1;
  localparam logic [TW-1:0] LAST = TW'(TASKS - 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RD   = 4'b0010,
    S_EX   = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t state;

  // input item fields
  logic [CMD_W-1:0]  in_cmd;
  logic [TASK_W-1:0] in_task;
  logic [DATA_W-1:0] in_value;

  assign in_cmd   = s_axis_tdata[2:0];
  assign in_task  = s_axis_tdata[6:3];
  assign in_value = s_axis_tdata[38:7];

  // latched command
  logic [CMD_W-1:0]  cmd_q;
  logic [DATA_W-1:0] value_q;
  logic [TW-1:0]     idx;      // row being read / updated
  logic [DATA_W-1:0] taken;
  logic [PEND_W-1:0] nz;       // task has nonzero flags (tasks 0..15 only)

  logic accept;
  logic task_ok;
  logic cmd_rowop;
  logic is_tick;

  assign s_axis_tready = (state == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign task_ok       = (32'(in_task) < TASKS);
  assign cmd_rowop     = (in_cmd == CMD_SEND) || (in_cmd == CMD_RECEIVE) ||
                         (in_cmd == CMD_ARM)  || (in_cmd == CMD_CANCEL);
  assign is_tick       = (cmd_q == CMD_TICK);

  // memory and update unit
  logic [TW-1:0]     rd_addr;
  row_t              rd_row;
  row_t              new_row;
  logic [DATA_W-1:0] upd_taken;
  logic              wr_en;

  // During a tick sweep the next row is read while the current one is written.
  assign rd_addr = (state == S_EX && is_tick && idx != LAST) ? TW'(idx + 1'b1) : idx;
  assign wr_en   = (state == S_EX);

  tefpt_mem #(
    .DEPTH (TASKS),
    .AW    (TW)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (rd_addr),
    .rd_data (rd_row),
    .wr_en   (wr_en),
    .wr_addr (idx),
    .wr_data (new_row)
  );

  tefpt_upd #(
    .TIMER_BIT (TIMER_BIT)
  ) u_upd (
    .cmd     (cmd_q),
    .value   (value_q),
    .row_in  (rd_row),
    .row_out (new_row),
    .taken   (upd_taken)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (in_cmd == CMD_TICK || (cmd_rowop && task_ok)) begin
              state <= S_RD;
            end else begin
              state <= S_DONE;   // bad task or unused code: no state change
            end
          end
        end
        S_RD: begin
          state <= S_EX;
        end
        S_EX: begin
          if (!is_tick || idx == LAST) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q   <= in_cmd;
      value_q <= in_value;
      idx     <= (in_cmd == CMD_TICK) ? '0 : TW'(in_task);
    end else if (state == S_EX && is_tick && idx != LAST) begin
      idx <= TW'(idx + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      taken <= '0;
    end else if (accept) begin
      taken <= '0;
    end else if (state == S_EX) begin
      taken <= upd_taken;
    end
  end

  // pending bits follow every row write
  always_ff @(posedge clk) begin
    if (rst) begin
      nz <= '0;
    end else if (wr_en) begin
      for (int j = 0; j < PEND_W; j++) begin
        if (j < TASKS && idx == TW'(j)) begin
          nz[j] <= (new_row.flags != '0);
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == S_DONE && (!m_axis_tvalid || m_axis_tready)) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!m_axis_tvalid || m_axis_tready)) begin
      m_axis_tdata <= {nz, taken};
    end
  end

  `ASSERT_CLK(a_single_row_done, (state == S_EX && !is_tick) |=> (state == S_DONE),
              "single-row command did not finish in one update")
  `ASSERT_CLK(a_busy_after_take, accept |=> !s_axis_tready, "took a second item while busy")
  `ASSERT_CLK(a_taken_only_recv, (state == S_DONE && cmd_q != CMD_RECEIVE) |-> (taken == '0),
              "matched events nonzero for a non-receive command")
  `ASSERT_CLK(a_sweep_in_range, (state == S_EX) |-> (idx <= LAST), "row index past last task")
  `ASSERT_CLK(a_result_from_done, $rose(m_axis_tvalid) |-> ($past(state) == S_DONE),
              "result shown without finishing a command")

endmodule
